// ===== hdl/teq_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
package teq_pkg;
	localparam int DefQueueDepth = 32;
	localparam int TimeW = 48;
	localparam logic [TimeW-1:0] TimeMax = {TimeW{1'b1}};

	localparam logic [1:0] KIND_ACK = 2'd0;
	localparam logic [1:0] KIND_FIRE = 2'd1;
	localparam logic [1:0] KIND_IDLE = 2'd2;

	localparam logic ACT_SCHED = 1'b0;
	localparam logic ACT_ADV = 1'b1;

	typedef struct packed {
		logic        action;
		logic [7:0]  type_id;
		logic [31:0] payload;
		logic [TimeW-1:0] due;
		logic [23:0] elapsed;
	} cmd_t;

	function automatic logic [TimeW-1:0] sat_add(input logic [TimeW-1:0] a,
		input logic [TimeW-1:0] b);
		logic [TimeW:0] s;
		s = {1'b0, a} + {1'b0, b};
		return s[TimeW] ? TimeMax : s[TimeW-1:0];
	endfunction
endpackage
`default_nettype wire

// ===== hdl/teq_front.sv =====
`timescale 1ns / 1ps
`default_nettype none
module teq_front import teq_pkg::*; (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_ready,
	input  wire logic        action,
	input  wire logic [7:0]  type_id,
	input  wire logic [31:0] payload,
	input  wire logic [31:0] delay_us,
	input  wire logic [31:0] type_delay_us,
	input  wire logic [23:0] elapsed_us,
	output logic             cmd_valid,
	input  wire logic        cmd_ready,
	output cmd_t             cmd
);
	// partial due: elapsed + delay + type delay (fits 34 bits, no saturation needed)
	logic [TimeW-1:0] part;
	logic             full_q;
	cmd_t             buf_q;

	always_comb begin
		part = TimeW'(elapsed_us) + TimeW'(delay_us) + TimeW'(type_delay_us);
	end

	assign in_ready = !full_q;
	assign cmd_valid = full_q;
	assign cmd = buf_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			full_q <= 1'b0;
		end else if (in_valid && in_ready) begin
			full_q <= 1'b1;
		end else if (cmd_ready) begin
			full_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			buf_q <= '{action: action, type_id: type_id, payload: payload,
				due: part, elapsed: elapsed_us};
		end
	end
endmodule
`default_nettype wire

// ===== hdl/teq_back.sv =====
`timescale 1ns / 1ps
`default_nettype none
module teq_back import teq_pkg::*; #(
	parameter int QueueDepth = DefQueueDepth
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             cmd_valid,
	output logic                  cmd_ready,
	input  cmd_t                  cmd,
	output logic                  out_valid,
	input  wire logic             out_ready,
	output logic [1:0]            kind,
	output logic                  status,
	output logic [7:0]            fired_id,
	output logic [31:0]           fired_payload,
	output logic [TimeW-1:0]      due_time,
	output logic                  last
);
	localparam int CW = $clog2(QueueDepth + 1);
	localparam int IW = (QueueDepth > 1) ? $clog2(QueueDepth) : 1;

	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_SRCH = 3'd1;
	localparam logic [2:0] ST_SHIFT = 3'd2;
	localparam logic [2:0] ST_FIRE = 3'd3;
	localparam logic [2:0] ST_WAIT = 3'd4;
	localparam logic [2:0] ST_COMP = 3'd5;

	logic [TimeW-1:0] due_q [QueueDepth];
	logic [7:0]       id_q [QueueDepth];
	logic [31:0]      pay_q [QueueDepth];

	logic [2:0]       state_q;
	logic [CW-1:0]    count_q;
	logic [TimeW-1:0] rt_q;
	logic [TimeW-1:0] new_due_q;
	logic [7:0]       new_id_q;
	logic [31:0]      new_pay_q;
	logic [CW-1:0]    pos_q;
	logic [CW-1:0]    nfire_q;

	// output register
	logic             ov_q;
	logic [1:0]       kind_q;
	logic             status_q;
	logic [7:0]       fid_q;
	logic [31:0]      fpay_q;
	logic [TimeW-1:0] odue_q;
	logic             last_q;

	logic             ofree;
	logic             ov_set;
	logic [IW-1:0]    pos_i;
	logic             head_due;

	assign ofree = !ov_q || out_ready;
	assign pos_i = pos_q[IW-1:0];
	assign cmd_ready = (state_q == ST_IDLE);
	assign head_due = (count_q != '0) && (due_q[0] < rt_q);
	assign ov_set = ofree && ((state_q == ST_COMP)
		|| ((state_q == ST_FIRE) && (head_due || (nfire_q == '0))));

	assign out_valid = ov_q;
	assign kind = kind_q;
	assign status = status_q;
	assign fired_id = fid_q;
	assign fired_payload = fpay_q;
	assign due_time = odue_q;
	assign last = last_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			count_q <= '0;
			rt_q <= '0;
			ov_q <= 1'b0;
			pos_q <= '0;
			nfire_q <= '0;
		end else begin
			if (ov_set) begin
				ov_q <= 1'b1;
			end else if (out_ready) begin
				ov_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (cmd_valid) begin
						if (cmd.action == ACT_SCHED) begin
							new_due_q <= sat_add(rt_q, cmd.due);
							new_id_q <= cmd.type_id;
							new_pay_q <= cmd.payload;
							pos_q <= '0;
							state_q <= ST_COMP;
						end else begin
							rt_q <= sat_add(rt_q, TimeW'(cmd.elapsed));
							nfire_q <= '0;
							state_q <= ST_FIRE;
						end
					end
				end
				ST_COMP: begin
					if (ofree) begin
						kind_q <= KIND_ACK;
						fid_q <= '0;
						fpay_q <= '0;
						odue_q <= new_due_q;
						last_q <= 1'b1;
						status_q <= (count_q >= CW'(QueueDepth));
						state_q <= (count_q >= CW'(QueueDepth)) ? ST_IDLE : ST_SRCH;
					end
				end
				ST_SRCH: begin
					if (pos_q < count_q && due_q[pos_i] <= new_due_q) begin
						pos_q <= pos_q + 1'b1;
					end else begin
						state_q <= ST_SHIFT;
					end
				end
				ST_SHIFT: begin
					if (count_q == pos_q) begin
						due_q[pos_i] <= new_due_q;
						id_q[pos_i] <= new_id_q;
						pay_q[pos_i] <= new_pay_q;
						count_q <= count_q + 1'b1;
						state_q <= ST_IDLE;
					end else begin
						for (int j = QueueDepth - 1; j > 0; j--) begin
							if (CW'(j) > pos_q) begin
								due_q[j] <= due_q[j-1];
								id_q[j] <= id_q[j-1];
								pay_q[j] <= pay_q[j-1];
							end
						end
						due_q[pos_i] <= new_due_q;
						id_q[pos_i] <= new_id_q;
						pay_q[pos_i] <= new_pay_q;
						count_q <= count_q + 1'b1;
						state_q <= ST_IDLE;
					end
				end
				ST_FIRE: begin
					if (ofree) begin
						if (head_due) begin
							kind_q <= KIND_FIRE;
							status_q <= 1'b0;
							fid_q <= id_q[0];
							fpay_q <= pay_q[0];
							odue_q <= due_q[0];
							last_q <= !((count_q > CW'(1)) && (due_q[1 % QueueDepth] < rt_q)
								&& (QueueDepth > 1));
							for (int j = 0; j < QueueDepth - 1; j++) begin
								due_q[j] <= due_q[j+1];
								id_q[j] <= id_q[j+1];
								pay_q[j] <= pay_q[j+1];
							end
							count_q <= count_q - 1'b1;
							nfire_q <= nfire_q + 1'b1;
						end else begin
							if (nfire_q == '0) begin
								kind_q <= KIND_IDLE;
								status_q <= 1'b0;
								fid_q <= '0;
								fpay_q <= '0;
								odue_q <= rt_q;
								last_q <= 1'b1;
							end
							state_q <= ST_IDLE;
						end
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end
endmodule
`default_nettype wire

// ===== hdl/timed_event_queue_core.sv =====
// Path to a result, schedule or advance: front buffer, back-end state, output register.
// Schedule: the ack comes first (status set if full), then a search and shift insert in due order.
// Advance: one fired event per cycle while the receiver keeps up.
// The back end takes a new command only once the previous one has finished.
// Reset: arst_n asynchronous, clears running time, entry count and handshake state.
`timescale 1ns / 1ps
`default_nettype none
module timed_event_queue_core import teq_pkg::*; #(
	parameter int QueueDepth = DefQueueDepth
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             in_valid,
	output logic                  in_ready,
	input  wire logic             action,
	input  wire logic [7:0]       type_id,
	input  wire logic [31:0]      payload,
	input  wire logic [31:0]      delay_us,
	input  wire logic [31:0]      type_delay_us,
	input  wire logic [23:0]      elapsed_us,
	output logic                  out_valid,
	input  wire logic             out_ready,
	output logic [1:0]            kind,
	output logic                  status,
	output logic [7:0]            fired_id,
	output logic [31:0]           fired_payload,
	output logic [TimeW-1:0]      due_time,
	output logic                  last
);
	logic cmd_valid;
	logic cmd_ready;
	cmd_t cmd;

	teq_front u_front (
		.clk, .arst_n, .in_valid, .in_ready, .action, .type_id, .payload,
		.delay_us, .type_delay_us, .elapsed_us, .cmd_valid, .cmd_ready, .cmd
	);

	teq_back #(.QueueDepth(QueueDepth)) u_back (
		.clk, .arst_n, .cmd_valid, .cmd_ready, .cmd, .out_valid, .out_ready,
		.kind, .status, .fired_id, .fired_payload, .due_time, .last
	);
endmodule
`default_nettype wire

// ===== hdl/teq_checker.sv =====
`timescale 1ns / 1ps
`default_nettype none
module teq_checker import teq_pkg::*; (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        out_valid,
	input wire logic        out_ready,
	input wire logic [1:0]  kind,
	input wire logic        status,
	input wire logic [7:0]  fired_id,
	input wire logic        last
);
	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(kind))
		else $error("result dropped while stalled");
	a_kind: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> kind != 2'd3)
		else $error("bad kind");
	a_ack_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && kind != KIND_FIRE |-> last)
		else $error("single result without last");
	a_status: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && kind != KIND_ACK |-> !status && (kind == KIND_FIRE || fired_id == 8'd0))
		else $error("status on non-ack");
endmodule

bind timed_event_queue_core teq_checker u_chk (
	.clk, .arst_n, .out_valid, .out_ready, .kind, .status, .fired_id, .last
);
`default_nettype wire
